// File: rtl/srfr_pkg.sv
// shared constants and types for the station reply frame receiver
package srfr_pkg;

  localparam logic [7:0] RESTART_BYTE   = 8'hFF;
  localparam logic [4:0] LEN_BIAS       = 5'd4;
  localparam logic [4:0] POS_HEADER     = 5'd2;
  localparam logic [4:0] POS_FIRST_DATA = 5'd3;
  localparam logic [4:0] POS_LAST_DATA  = 5'd6;

  // header bytes
  localparam logic [7:0] HDR_TRACK_CV  = 8'h61;
  localparam logic [7:0] HDR_CV_RESULT = 8'h63;
  localparam logic [7:0] HDR_LOCO_MISC = 8'hE3;
  localparam logic [7:0] HDR_LOCO_INFO = 8'hE4;

  // codes in the byte after the header
  localparam logic [7:0] CODE_POWER_OFF   = 8'h00;
  localparam logic [7:0] CODE_POWER_ON    = 8'h01;
  localparam logic [7:0] CODE_PROG_MODE   = 8'h02;
  localparam logic [7:0] CODE_CV_READY    = 8'h11;
  localparam logic [7:0] CODE_CV_SHORT    = 8'h12;
  localparam logic [7:0] CODE_NO_DECODER  = 8'h13;
  localparam logic [7:0] CODE_CV_BUSY     = 8'h1F;
  localparam logic [7:0] CODE_CV_DIRECT   = 8'h14;
  localparam logic [7:0] CODE_CV_PAGE1    = 8'h15;
  localparam logic [7:0] CODE_CV_PAGE2    = 8'h16;
  localparam logic [7:0] CODE_CV_PAGE3    = 8'h17;
  localparam logic [7:0] CODE_VERSION     = 8'h21;
  localparam logic [7:0] CODE_LOCO_BUSY   = 8'h40;
  localparam logic [7:0] CODE_FUNC_STATUS = 8'h52;

  localparam logic [10:0] CV_ZERO_ALIAS = 11'd1024;

  localparam logic [1:0] TRACK_OFF = 2'd0;
  localparam logic [1:0] TRACK_ON  = 2'd1;
  localparam logic [1:0] TRACK_PROG = 2'd2;

  localparam logic [1:0] CVS_OK          = 2'd0;
  localparam logic [1:0] CVS_NO_DECODER  = 2'd1;
  localparam logic [1:0] CVS_READY_SHORT = 2'd2;
  localparam logic [1:0] CVS_BUSY        = 2'd3;

  typedef struct packed {
    logic [7:0] header;
    logic       xor_good;
    logic [7:0] code;
    logic [7:0] b4;
    logic [7:0] b5;
    logic [7:0] b6;
  } frame_t;

  typedef struct packed {
    logic [1:0]  track;
    logic [1:0]  cv_status;
    logic [10:0] cv_number;
    logic [7:0]  cv_data;
    logic [7:0]  busy_loco;
    logic [7:0]  speed;
    logic [7:0]  fg_one;
    logic [7:0]  fg_two;
    logic [7:0]  fg_three;
    logic [7:0]  version;
  } station_t;

  typedef struct packed {
    logic [7:0] header;
    logic       checksum_good;
    station_t   station;
  } result_t;

endpackage

// File: rtl/srfr_parser.sv
// byte position, length, running xor and data byte capture
module srfr_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         rx_byte,
  output logic               done,
  output srfr_pkg::frame_t   frame
);
  import srfr_pkg::*;

  logic [4:0] pos;
  logic [4:0] len;
  logic [7:0] xor_acc;
  logic [7:0] header;
  logic [7:0] fbytes [4];

  logic [4:0] pos_eff;
  logic [4:0] pos_inc;
  logic [4:0] pos_next;
  logic [4:0] len_upd;
  logic [4:0] len_next;
  logic [7:0] xor_next;
  logic [7:0] header_next;
  logic [1:0] slot;
  logic       wr;
  logic       last;
  logic [7:0] fb_cur [4];

  always_comb begin
    pos_eff     = (rx_byte == RESTART_BYTE) ? '0 : pos;
    len_upd     = len;
    header_next = header;
    xor_next    = xor_acc;
    if (pos_eff == POS_HEADER) begin
      len_upd     = {1'b0, rx_byte[3:0]} + LEN_BIAS;
      header_next = rx_byte;
      xor_next    = rx_byte;
    end else if (pos_eff > POS_HEADER) begin
      xor_next = xor_acc ^ rx_byte;
    end
    wr   = (pos_eff >= POS_FIRST_DATA) && (pos_eff <= POS_LAST_DATA);
    slot = 2'(pos_eff - POS_FIRST_DATA);
    for (int i = 0; i < 4; i++) begin
      fb_cur[i] = (wr && slot == 2'(i)) ? rx_byte : fbytes[i];
    end
    pos_inc  = pos_eff + 5'd1;
    last     = (pos_inc == len_upd);
    pos_next = last ? '0 : pos_inc;
    len_next = last ? '0 : len_upd;
  end

  assign done           = accept && last;
  assign frame.header   = header_next;
  assign frame.xor_good = (xor_next == 8'd0);
  assign frame.code     = fb_cur[0];
  assign frame.b4       = fb_cur[1];
  assign frame.b5       = fb_cur[2];
  assign frame.b6       = fb_cur[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      len     <= '0;
      xor_acc <= '0;
      header  <= '0;
    end else if (accept) begin
      pos     <= pos_next;
      len     <= len_next;
      xor_acc <= xor_next;
      header  <= header_next;
    end
  end

  // data bytes hold whatever the last frame that reached them left
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 4; i++) begin
        fbytes[i] <= fb_cur[i];
      end
    end
  end

  a_pos_below_len: assert property (@(posedge clk) disable iff (rst)
    (pos <= POS_HEADER) || (pos < len))
    else $error("byte position ran past frame length");

  a_len_from_header: assert property (@(posedge clk) disable iff (rst)
    (pos > POS_HEADER) |-> (len == ({1'b0, header[3:0]} + LEN_BIAS)))
    else $error("frame length does not follow header nibble");

endmodule

// File: rtl/srfr_state.sv
// tracked station state, updated from each completed frame
module srfr_state (
  input  logic                clk,
  input  logic                rst,
  input  logic                done,
  input  srfr_pkg::frame_t    frame,
  output srfr_pkg::station_t  station_next
);
  import srfr_pkg::*;

  station_t station;

  always_comb begin
    station_next = station;
    unique case (frame.header)
      HDR_TRACK_CV: begin
        unique case (frame.code) inside
          CODE_POWER_OFF, CODE_POWER_ON, CODE_PROG_MODE:
            station_next.track = frame.code[1:0];
          CODE_CV_READY, CODE_CV_SHORT: station_next.cv_status = CVS_READY_SHORT;
          CODE_NO_DECODER:              station_next.cv_status = CVS_NO_DECODER;
          CODE_CV_BUSY:                 station_next.cv_status = CVS_BUSY;
          default: ;
        endcase
      end
      HDR_CV_RESULT: begin
        unique case (frame.code) inside
          CODE_CV_DIRECT: begin
            // cv 0 on the wire means cv 1024
            station_next.cv_number = (frame.b4 == 8'd0) ? CV_ZERO_ALIAS
                                                        : {3'b000, frame.b4};
            station_next.cv_data   = frame.b5;
            station_next.cv_status = CVS_OK;
          end
          CODE_CV_PAGE1, CODE_CV_PAGE2, CODE_CV_PAGE3: begin
            // page 1..3 adds 256 per page
            station_next.cv_number = {1'b0, frame.code[1:0], frame.b4};
            station_next.cv_data   = frame.b5;
          end
          CODE_VERSION: station_next.version = frame.b4;
          default: ;
        endcase
      end
      HDR_LOCO_MISC: begin
        unique case (frame.code) inside
          CODE_LOCO_BUSY: station_next.busy_loco = frame.b5;
          CODE_FUNC_STATUS: begin
            station_next.fg_two   = frame.b4;
            station_next.fg_three = frame.b5;
          end
          default: ;
        endcase
      end
      HDR_LOCO_INFO: begin
        station_next.speed  = frame.b4;
        station_next.fg_one = frame.b5;
        station_next.fg_two = frame.b6;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      station <= '0;
    end else if (done) begin
      station <= station_next;
    end
  end

  a_track_legal: assert property (@(posedge clk) disable iff (rst)
    station.track != 2'd3)
    else $error("track state took an unused code");

endmodule

// File: rtl/srfr_out.sv
// result register with one skid entry
module srfr_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  srfr_pkg::result_t  push_data,
  input  logic               frame_stall,
  output logic               frame_valid,
  output srfr_pkg::result_t  frame_data,
  output logic               busy
);
  import srfr_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    take;
  logic    load_out;
  logic    load_skid;

  assign take      = frame_valid && !frame_stall;
  assign load_out  = push && !skid_valid && (!frame_valid || take);
  assign load_skid = push && !skid_valid && frame_valid && !take;
  assign busy      = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      frame_valid <= 1'b1;
      skid_valid  <= load_skid;
    end else if (take) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid && take) begin
      frame_data <= skid_data;
    end else if (load_out) begin
      frame_data <= push_data;
    end
    if (load_skid) begin
      skid_data <= push_data;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> frame_valid)
    else $error("skid entry held with empty output register");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(frame_valid && frame_stall))
    else $error("skid filled while output beat could move");

  a_no_push_busy: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("result pushed while skid full");

endmodule

// File: rtl/station_reply_frame_receiver.sv
// Station reply frame receiver: one received byte per beat, one result beat per frame.
// Takes one byte per cycle while byte_stall is low; a frame result is registered on its
// last byte. byte_stall rises only when a result sits in the output register and a second
// one waits in the skid entry behind it, and drops the cycle after a result is taken.
// A 0xFF byte restarts the frame; the header is the third byte and its low nibble plus four
// gives the frame length. Each result carries the header, the checksum flag and the whole
// tracked station state after that frame, which is applied whatever the checksum.
module station_reply_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  rx_byte,
  output logic        frame_valid,
  input  logic        frame_stall,
  output logic [7:0]  frame_header,
  output logic        checksum_good,
  output logic [1:0]  track_state,
  output logic [1:0]  cv_status,
  output logic [10:0] cv_number,
  output logic [7:0]  cv_data,
  output logic [7:0]  busy_loco,
  output logic [7:0]  speed_byte,
  output logic [7:0]  func_group_one,
  output logic [7:0]  func_group_two,
  output logic [7:0]  func_group_three,
  output logic [7:0]  station_version
);
  import srfr_pkg::*;

  logic     accept;
  logic     done;
  frame_t   frame;
  station_t station_next;
  result_t  push_data;
  result_t  frame_data;
  logic     busy;

  assign byte_stall = busy;
  assign accept     = byte_valid && !busy;

  srfr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .done    (done),
    .frame   (frame)
  );

  srfr_state u_state (
    .clk          (clk),
    .rst          (rst),
    .done         (done),
    .frame        (frame),
    .station_next (station_next)
  );

  assign push_data.header        = frame.header;
  assign push_data.checksum_good = frame.xor_good;
  assign push_data.station       = station_next;

  srfr_out u_out (
    .clk         (clk),
    .rst         (rst),
    .push        (done),
    .push_data   (push_data),
    .frame_stall (frame_stall),
    .frame_valid (frame_valid),
    .frame_data  (frame_data),
    .busy        (busy)
  );

  assign frame_header     = frame_data.header;
  assign checksum_good    = frame_data.checksum_good;
  assign track_state      = frame_data.station.track;
  assign cv_status        = frame_data.station.cv_status;
  assign cv_number        = frame_data.station.cv_number;
  assign cv_data          = frame_data.station.cv_data;
  assign busy_loco        = frame_data.station.busy_loco;
  assign speed_byte       = frame_data.station.speed;
  assign func_group_one   = frame_data.station.fg_one;
  assign func_group_two   = frame_data.station.fg_two;
  assign func_group_three = frame_data.station.fg_three;
  assign station_version  = frame_data.station.version;

endmodule
